/* rtl/cbm_pkg.sv */
package cbm_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_VIDEO = 2'd2,
      CMD_NOP   = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      CSR_BOARD_VARIANT = 2'd0,
      CSR_PRG_BANK_MASK = 2'd1,
      CSR_CHR_BANK_MASK = 2'd2
   } csr_index_type;

   localparam logic [15:0] CHR_REG_FIRST  = 16'h7EF0;
   localparam logic [15:0] CHR_REG_LAST   = 16'h7EF5;
   localparam logic [15:0] MIRROR_REG     = 16'h7EF6;
   localparam logic [15:0] PRG_REG_FIRST  = 16'h7EFA;
   localparam logic [15:0] PRG_REG_LAST   = 16'h7EFF;
   localparam logic [7:0]  RAM_PAGE       = 8'h7F;
   localparam logic [5:0]  PALETTE_PAGE   = 6'h3F;
   localparam logic [3:0]  PRG_REG_BASE   = 4'hA;
   localparam logic [7:0]  FIXED_PRG_BANK = 8'hFF;
   localparam logic [7:0]  PRG_BANK1_INIT = 8'h01;
   localparam logic [7:0]  PRG_BANK2_INIT = 8'hFE;

   typedef struct packed {
      logic            board_variant;
      logic [7:0]      prg_bank_mask;
      logic [7:0]      chr_bank_mask;
      logic [2:0][7:0] program_banks;
      logic [5:0][7:0] character_banks;
      logic            mirror_select;
   } bank_state_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        ram_hit;
      logic [20:0] prg_address;
      logic        prg_hit;
      logic [17:0] chr_address;
      logic        chr_hit;
      logic        ciram_a10;
      logic        nametable_hit;
   } rsp_payload_type;

endpackage

/* rtl/cbm_if.sv */
interface cbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source (output valid, command, address, write_data, input ready);
   modport sink (input valid, command, address, write_data, output ready);
endinterface

interface cbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic        ram_hit;
   logic [20:0] prg_address;
   logic        prg_hit;
   logic [17:0] chr_address;
   logic        chr_hit;
   logic        ciram_a10;
   logic        nametable_hit;

   modport source (output valid, read_data, ram_hit, prg_address, prg_hit, chr_address,
                   chr_hit, ciram_a10, nametable_hit, input ready);
   modport sink (input valid, read_data, ram_hit, prg_address, prg_hit, chr_address,
                 chr_hit, ciram_a10, nametable_hit, output ready);
endinterface

/* rtl/cbm_regs.sv */
module cbm_regs
   import cbm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_enable,
   input  logic [1:0]     csr_index,
   input  logic [7:0]     csr_write_data,
   input  logic           cpu_write,
   input  logic [15:0]    address,
   input  logic [7:0]     write_data,
   output bank_state_type state
);

   bank_state_type state_ff;
   bank_state_type state_in;
   logic [3:0]     prg_offset;

   assign prg_offset = address[3:0] - PRG_REG_BASE;

   always_comb begin
      state_in = state_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_BOARD_VARIANT: state_in.board_variant = csr_write_data[0];
            CSR_PRG_BANK_MASK: state_in.prg_bank_mask = csr_write_data;
            CSR_CHR_BANK_MASK: state_in.chr_bank_mask = csr_write_data;
            default: ;
         endcase
      end
      if (cpu_write) begin
         if (address >= CHR_REG_FIRST && address <= CHR_REG_LAST) begin
            state_in.character_banks[address[2:0]] = write_data;
         end else if (address == MIRROR_REG) begin
            state_in.mirror_select = write_data[0];
         end else if (address >= PRG_REG_FIRST && address <= PRG_REG_LAST) begin
            // Register pairs share one bank: offsets 0-1, 2-3 and 4-5.
            state_in.program_banks[prg_offset[2:1]] = write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.board_variant   <= 1'b0;
         state_ff.prg_bank_mask   <= 8'hFF;
         state_ff.chr_bank_mask   <= 8'hFF;
         state_ff.program_banks   <= {PRG_BANK2_INIT, PRG_BANK1_INIT, 8'h00};
         state_ff.character_banks <= '0;
         state_ff.mirror_select   <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

/* rtl/cbm_ram.sv */
module cbm_ram
   import cbm_pkg::*;
#(
   parameter int RAM_BYTES = 128
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         access,
   input  logic                         write_enable,
   input  logic [$clog2(RAM_BYTES)-1:0] index,
   input  logic [7:0]                   write_data,
   output logic [7:0]                   read_data
);

   logic [7:0]           mem [RAM_BYTES];
   logic [RAM_BYTES-1:0] valid_ff;
   logic [RAM_BYTES-1:0] valid_in;
   logic [7:0]           rd_data_ff;
   logic                 rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (write_enable) begin
         valid_in[index] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[index] <= write_data;
      end
   end

   // The read is taken when a word enters the pipeline and held while it waits.
   always_ff @(posedge clock) begin
      if (access) begin
         rd_data_ff  <= mem[index];
         rd_valid_ff <= valid_ff[index];
      end
   end

   // A byte never written since reset reads as zero.
   assign read_data = rd_valid_ff ? rd_data_ff : 8'h00;

endmodule

/* rtl/cbm_xlat.sv */
module cbm_xlat
   import cbm_pkg::*;
(
   input  logic            [1:0]  command,
   input  logic            [15:0] address,
   input  logic            [7:0]  ram_data,
   input  bank_state_type         state,
   output rsp_payload_type        result
);

   logic [13:0] vaddr;
   logic [1:0]  prg_slot;
   logic [7:0]  prg_bank;
   logic [2:0]  chr_index;
   logic [7:0]  chr_reg;
   logic [7:0]  chr_bank;

   assign vaddr    = address[13:0];
   assign prg_slot = address[14:13];
   assign prg_bank = ((prg_slot == 2'd3) ? FIXED_PRG_BANK : state.program_banks[prg_slot])
                     & state.prg_bank_mask;

   // The lower pattern half uses 2K banks from registers 0 and 1, the upper half
   // uses 1K banks from registers 2 to 5.
   assign chr_index = vaddr[12] ? (3'd2 + {1'b0, vaddr[11:10]}) : {2'b00, vaddr[11]};
   assign chr_reg   = state.character_banks[chr_index];
   assign chr_bank  = (vaddr[12] ? chr_reg : {chr_reg[7:1], vaddr[10]}) & state.chr_bank_mask;

   always_comb begin
      result = '0;
      case (command)
         CMD_READ: begin
            if (address[15]) begin
               result.prg_address = {prg_bank, address[12:0]};
               result.prg_hit     = 1'b1;
            end else if (address[15:8] == RAM_PAGE && !state.board_variant) begin
               result.read_data = ram_data;
               result.ram_hit   = 1'b1;
            end
         end
         CMD_VIDEO: begin
            if (!vaddr[13]) begin
               result.chr_address = {chr_bank, vaddr[9:0]};
               result.chr_hit     = 1'b1;
            end else if (vaddr[13:8] != PALETTE_PAGE) begin
               if (state.board_variant) begin
                  // Nametables 0-1 follow bank register 0, nametables 2-3 register 1.
                  result.ciram_a10 = state.character_banks[{2'b00, vaddr[11]}][7];
               end else if (state.mirror_select) begin
                  result.ciram_a10 = vaddr[10];
               end else begin
                  result.ciram_a10 = vaddr[11];
               end
               result.nametable_hit = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

/* rtl/cartridge_bank_mapper_unit.sv */
// A word accepted on req is held in the decode stage, then its translation is registered
// into the result register that drives rsp, where it waits until rsp is ready.
// Throughput: one word per cycle while rsp is ready; the decode stage and the result
// register form a two-deep pipeline, so a new word is taken while a finished result waits.
// Reset (synchronous, active high) restores the variant, bank, mirroring and mask registers
// and marks every internal RAM byte unwritten, so a read of it after reset returns zero.
module cartridge_bank_mapper_unit
   import cbm_pkg::*;
#(
   parameter int RAM_BYTES = 128
)
(
   input  logic        clock,
   input  logic        reset,
   cbm_req_if.sink     req_if,
   cbm_rsp_if.source   rsp_if,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   localparam int RAM_AW = $clog2(RAM_BYTES);

   logic            req_accept;
   logic            stage_advance;
   logic            stage_valid_ff;
   logic            stage_valid_in;
   logic [1:0]      stage_cmd_ff;
   logic [15:0]     stage_addr_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_ff;
   rsp_payload_type result;
   bank_state_type  state;
   logic            cpu_write;
   logic            ram_write;
   logic [7:0]      ram_data;

   assign stage_advance = stage_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready  = !stage_valid_ff || stage_advance;
   assign req_accept    = req_if.valid && req_if.ready;

   // Writes take effect as the word is accepted; the word ahead of it has
   // already left the decode stage at the same edge.
   assign cpu_write = req_accept && (req_if.command == CMD_WRITE);
   assign ram_write = cpu_write && (req_if.address[15:8] == RAM_PAGE) && !state.board_variant;

   cbm_regs u_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cpu_write        (cpu_write),
      .address          (req_if.address),
      .write_data       (req_if.write_data),
      .state            (state)
   );

   cbm_ram #(
      .RAM_BYTES (RAM_BYTES)
   ) u_ram (
      .clock        (clock),
      .reset        (reset),
      .access       (req_accept),
      .write_enable (ram_write),
      .index        (req_if.address[RAM_AW-1:0]),
      .write_data   (req_if.write_data),
      .read_data    (ram_data)
   );

   cbm_xlat u_xlat (
      .command (stage_cmd_ff),
      .address (stage_addr_ff),
      .ram_data(ram_data),
      .state   (state),
      .result  (result)
   );

   assign stage_valid_in = req_accept || (stage_valid_ff && !stage_advance);
   assign out_valid_in   = stage_advance || (out_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_cmd_ff  <= req_if.command;
         stage_addr_ff <= req_if.address;
      end
      if (stage_advance) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.read_data     = out_ff.read_data;
   assign rsp_if.ram_hit       = out_ff.ram_hit;
   assign rsp_if.prg_address   = out_ff.prg_address;
   assign rsp_if.prg_hit       = out_ff.prg_hit;
   assign rsp_if.chr_address   = out_ff.chr_address;
   assign rsp_if.chr_hit       = out_ff.chr_hit;
   assign rsp_if.ciram_a10     = out_ff.ciram_a10;
   assign rsp_if.nametable_hit = out_ff.nametable_hit;

endmodule

/* bench/cartridge_bank_mapper_unit_checker.sv */
module cartridge_bank_mapper_unit_checker
   import cbm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cbm_req_if         req_mon,
   cbm_rsp_if         rsp_mon,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data,
   output int         mismatch_count,
   output int         pending_count
);

   localparam int RAM_BYTES = 128;
   localparam int MAX_REPORTS = 200;

   logic            variant_q;
   logic [7:0]      prg_mask_q;
   logic [7:0]      chr_mask_q;
   logic [7:0]      prg_bank_q [3];
   logic [7:0]      chr_bank_q [6];
   logic            mirror_q;
   logic [7:0]      work_ram_q [RAM_BYTES];

   rsp_payload_type expected_maps [$];
   rsp_payload_type observed;
   rsp_payload_type wanted;
   int              mismatches;

   // Applies one bus word to the mapper state and returns the translation it yields.
   function automatic rsp_payload_type map_bus_word(command_type cmd, logic [15:0] addr,
                                                    logic [7:0] data);
      rsp_payload_type result;
      logic [13:0]     vaddr;
      logic [7:0]      bank;
      int              prg_slot;
      result = '0;
      case (cmd)
         CMD_WRITE: begin
            if (addr >= CHR_REG_FIRST && addr <= CHR_REG_LAST) begin
               chr_bank_q[addr[2:0]] = data;
            end else if (addr == MIRROR_REG) begin
               mirror_q = data[0];
            end else if (addr >= PRG_REG_FIRST && addr <= PRG_REG_LAST) begin
               prg_slot = (int'(addr) - int'(PRG_REG_FIRST)) / 2;
               prg_bank_q[prg_slot] = data;
            end else if (addr[15:8] == RAM_PAGE && !variant_q) begin
               work_ram_q[addr[6:0]] = data;
            end
         end
         CMD_READ: begin
            if (addr[15]) begin
               // The top 8K window always maps the last bank.
               bank = (addr[14:13] == 2'd3) ? FIXED_PRG_BANK : prg_bank_q[addr[14:13]];
               bank = bank & prg_mask_q;
               result.prg_address = {bank, addr[12:0]};
               result.prg_hit = 1'b1;
            end else if (addr[15:8] == RAM_PAGE && !variant_q) begin
               result.read_data = work_ram_q[addr[6:0]];
               result.ram_hit = 1'b1;
            end
         end
         CMD_VIDEO: begin
            vaddr = addr[13:0];
            if (!vaddr[13]) begin
               if (!vaddr[12]) begin
                  bank = {chr_bank_q[vaddr[11]][7:1], vaddr[10]};
               end else begin
                  bank = chr_bank_q[int'(vaddr[11:10]) + 2];
               end
               bank = bank & chr_mask_q;
               result.chr_address = {bank, vaddr[9:0]};
               result.chr_hit = 1'b1;
            end else if (vaddr[13:8] != PALETTE_PAGE) begin
               if (variant_q) begin
                  result.ciram_a10 = chr_bank_q[vaddr[11]][7];
               end else if (mirror_q) begin
                  result.ciram_a10 = vaddr[10];
               end else begin
                  result.ciram_a10 = vaddr[11];
               end
               result.nametable_hit = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   task automatic check_field(string field, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, expected, actual);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         variant_q = 1'b0;
         prg_mask_q = 8'hFF;
         chr_mask_q = 8'hFF;
         prg_bank_q[0] = 8'h00;
         prg_bank_q[1] = PRG_BANK1_INIT;
         prg_bank_q[2] = PRG_BANK2_INIT;
         foreach (chr_bank_q[i]) chr_bank_q[i] = 8'h00;
         mirror_q = 1'b0;
         foreach (work_ram_q[i]) work_ram_q[i] = 8'h00;
         expected_maps.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            observed.read_data     = rsp_mon.read_data;
            observed.ram_hit       = rsp_mon.ram_hit;
            observed.prg_address   = rsp_mon.prg_address;
            observed.prg_hit       = rsp_mon.prg_hit;
            observed.chr_address   = rsp_mon.chr_address;
            observed.chr_hit       = rsp_mon.chr_hit;
            observed.ciram_a10     = rsp_mon.ciram_a10;
            observed.nametable_hit = rsp_mon.nametable_hit;
            if (expected_maps.size() == 0) begin
               mismatches++;
               $display("%0t: result word with nothing expected, expected none, actual 0x%0h",
                        $time, observed);
            end else begin
               wanted = expected_maps.pop_front();
               check_field("read_data", wanted.read_data, observed.read_data);
               check_field("ram_hit", wanted.ram_hit, observed.ram_hit);
               check_field("prg_address", wanted.prg_address, observed.prg_address);
               check_field("prg_hit", wanted.prg_hit, observed.prg_hit);
               check_field("chr_address", wanted.chr_address, observed.chr_address);
               check_field("chr_hit", wanted.chr_hit, observed.chr_hit);
               check_field("ciram_a10", wanted.ciram_a10, observed.ciram_a10);
               check_field("nametable_hit", wanted.nametable_hit, observed.nametable_hit);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_maps.push_back(map_bus_word(command_type'(req_mon.command),
                                                 req_mon.address, req_mon.write_data));
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_BOARD_VARIANT: variant_q = csr_write_data[0];
               CSR_PRG_BANK_MASK: prg_mask_q = csr_write_data;
               CSR_CHR_BANK_MASK: chr_mask_q = csr_write_data;
               default: begin
               end
            endcase
         end
      end
      mismatch_count <= mismatches;
      pending_count <= expected_maps.size();
   end

endmodule

/* bench/cartridge_bank_mapper_unit_test.sv */
module cartridge_bank_mapper_unit_test;
   import cbm_pkg::*;

   localparam int PHASES = 6;
   localparam int WORDS_PER_PHASE = 190;
   localparam int QUIET_WORDS = 120;
   localparam int HOLD_CYCLES = 60;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;
   int         mismatch_count;
   int         pending_count;

   int         idle_odds;
   logic       quiet_tail;
   logic       hold_rsp;
   int         stall_left;
   int         words_by_command [4];

   cbm_req_if req_ch ();
   cbm_rsp_if rsp_ch ();

   cartridge_bank_mapper_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_ch),
      .rsp_if           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   cartridge_bank_mapper_unit_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("[cartridge_bank_mapper_unit] ERROR");
      $finish;
   end

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin
      stall_left = 0;
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !quiet_tail && idle_odds != 0 &&
                      $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 7);
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_word(command_type cmd, logic [15:0] addr, logic [7:0] data);
      if (!quiet_tail && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.command <= cmd;
      req_ch.address <= addr;
      req_ch.write_data <= data;
      do @(posedge clock); while (!req_ch.ready);
      words_by_command[cmd]++;
   endtask

   // Most words hit the register and RAM windows or the mapped ROM ranges, so the
   // bank state keeps changing between translations.
   task automatic send_random_word();
      command_type cmd;
      logic [15:0] addr;
      int          pick;
      pick = $urandom_range(0, 99);
      cmd = (pick < 35) ? CMD_WRITE : (pick < 65) ? CMD_READ :
            (pick < 95) ? CMD_VIDEO : CMD_NOP;
      pick = $urandom_range(0, 99);
      case (cmd)
         CMD_WRITE: addr = (pick < 45) ? CHR_REG_FIRST + 16'($urandom_range(0, 15)) :
                           (pick < 80) ? {RAM_PAGE, 8'($urandom)} : 16'($urandom);
         CMD_READ:  addr = (pick < 35) ? {RAM_PAGE, 8'($urandom)} :
                           (pick < 80) ? {1'b1, 15'($urandom)} : 16'($urandom);
         CMD_VIDEO: addr = (pick < 90) ? {2'b00, 14'($urandom)} : 16'($urandom);
         default:   addr = 16'($urandom);
      endcase
      send_word(cmd, addr, 8'($urandom));
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [7:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      logic [7:0] prg_mask;
      logic [7:0] chr_mask;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.command <= CMD_NOP;
      req_ch.address <= 16'h0000;
      req_ch.write_data <= 8'h00;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_BOARD_VARIANT;
      csr_write_data <= 8'h00;
      idle_odds = 0;
      quiet_tail = 1'b0;
      hold_rsp = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults: variant 0, both masks all ones.
      idle_odds = 3;
      send_word(CMD_READ, 16'h7F00, 8'h00);
      send_word(CMD_WRITE, 16'h7F05, 8'hA5);
      send_word(CMD_READ, 16'h7F85, 8'h00);
      send_word(CMD_WRITE, CHR_REG_FIRST, 8'hFF);
      send_word(CMD_WRITE, 16'h7EF1, 8'h81);
      send_word(CMD_WRITE, 16'h7EF2, 8'h80);
      send_word(CMD_WRITE, CHR_REG_LAST, 8'h7F);
      send_word(CMD_WRITE, MIRROR_REG, 8'h01);
      send_word(CMD_WRITE, 16'h7EF8, 8'h55);
      send_word(CMD_WRITE, PRG_REG_FIRST, 8'h12);
      send_word(CMD_WRITE, 16'h7EFD, 8'hFF);
      send_word(CMD_READ, 16'h8000, 8'h00);
      send_word(CMD_READ, 16'hBFFF, 8'h00);
      send_word(CMD_READ, 16'hC000, 8'h00);
      send_word(CMD_READ, 16'hFFFF, 8'h00);
      send_word(CMD_READ, 16'h0000, 8'h00);
      send_word(CMD_READ, CHR_REG_FIRST, 8'h00);
      send_word(CMD_VIDEO, 16'h0000, 8'h00);
      send_word(CMD_VIDEO, 16'h0FFF, 8'h00);
      send_word(CMD_VIDEO, 16'h1FFF, 8'h00);
      send_word(CMD_VIDEO, 16'h2400, 8'h00);
      send_word(CMD_VIDEO, 16'h3EFF, 8'h00);
      send_word(CMD_VIDEO, 16'h3F00, 8'h00);
      send_word(CMD_VIDEO, 16'hFFFF, 8'h00);
      send_word(CMD_VIDEO, 16'h4000, 8'h00);
      send_word(CMD_NOP, 16'hFFFF, 8'hFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin prg_mask = 8'hFF; chr_mask = 8'hFF; end
            1: begin prg_mask = 8'h00; chr_mask = 8'h00; end
            2: begin prg_mask = 8'h0F; chr_mask = 8'h3F; end
            5: begin prg_mask = 8'hFF; chr_mask = 8'hFF; end
            default: begin prg_mask = 8'($urandom); chr_mask = 8'($urandom); end
         endcase
         write_csr(CSR_BOARD_VARIANT, (phase % 2 == 0) ? 8'h01 : 8'hFE);
         write_csr(CSR_PRG_BANK_MASK, prg_mask);
         write_csr(CSR_CHR_BANK_MASK, chr_mask);
         idle_odds = $urandom_range(0, 6);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            // The sender keeps offering words through this stall so the pipe backs up.
            if (phase == 1 && n == 40) hold_rsp = 1'b1;
            if (phase == PHASES - 1 && n == WORDS_PER_PHASE - QUIET_WORDS) quiet_tail = 1'b1;
            send_random_word();
         end
      end

      wait_idle();
      repeat (4) @(posedge clock);
      $display("Covered %0d words: %0d writes, %0d reads, %0d video accesses, %0d no-ops.",
               words_by_command[CMD_WRITE] + words_by_command[CMD_READ] +
               words_by_command[CMD_VIDEO] + words_by_command[CMD_NOP],
               words_by_command[CMD_WRITE], words_by_command[CMD_READ],
               words_by_command[CMD_VIDEO], words_by_command[CMD_NOP]);
      $display("Both board variants, masks from 0x00 to 0xFF and one %0d-cycle result stall.",
               HOLD_CYCLES);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("[cartridge_bank_mapper_unit] OK");
      end else begin
         $display("[cartridge_bank_mapper_unit] ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/cbm_pkg.sv
rtl/cbm_if.sv
rtl/cbm_regs.sv
rtl/cbm_ram.sv
rtl/cbm_xlat.sv
rtl/cartridge_bank_mapper_unit.sv
bench/cartridge_bank_mapper_unit_checker.sv
bench/cartridge_bank_mapper_unit_test.sv
